// ===== hw/rtl/diff_drive_odometry_integrator_unit_defines.svh =====
// Assertion macros for the odometry integrator.
// Used by the top level only; expects signals named clk and rst_n in scope.
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DDOI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDOI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ddoi_pkg.sv =====
// Shared constants, types and the arctangent table of the odometry integrator.
// No dependencies; used by every module of the block.
package ddoi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_IW    = $clog2(CORDIC_STEPS + 1);
    localparam int ATAN_IW      = 5;
    localparam int CS_W         = 30;
    localparam int CZ_W         = 33;
    localparam int MD_W         = 64;
    localparam int MD_CW        = $clog2(MD_W + 1);

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 30'sd40752055;
    localparam logic [30:0] INV_PI_Q32   = 31'd1367130551;
    localparam logic [4:0]  OMEGA_FLOOR  = 5'd17;
    localparam logic [15:0] RADIUS_RESET = 16'd2163;
    localparam logic [17:0] BASE_RESET   = 18'd10486;

    typedef enum logic [0:0] {
        REG_WHEEL_RADIUS = 1'b0,
        REG_WHEEL_BASE   = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        MD_MUL = 1'b0,
        MD_DIV = 1'b1
    } md_op_t;

    typedef struct packed {
        logic                   start;
        md_op_t                 op;
        logic signed [MD_W-1:0] a;
        logic signed [MD_W-1:0] b;
        logic [MD_CW-1:0]       nbits;
    } md_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [MD_W-1:0] result;
    } md_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cd_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [CS_W-1:0] sin;
        logic signed [CS_W-1:0] cos;
    } cd_rsp_t;

    // Arctangent of 2^-i, full turn equal to 2^32.
    function automatic logic signed [CZ_W-1:0] atan_angle(input logic [ATAN_IW-1:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            5'd20:   v = 33'sd652;
            5'd21:   v = 33'sd326;
            5'd22:   v = 33'sd163;
            5'd23:   v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/diff_drive_odometry_integrator_unit.sv =====
// Differential-drive odometry integrator, top level.
// Depends on ddoi_pkg, ddoi_muldiv, ddoi_cordic and the assertion macro header.
//
// Each request on the input channel (in_valid/in_ready) carries the two wheel
// rates and a time step; exactly one result per request leaves on the output
// channel (out_valid/out_ready): pose x, pose y, heading and travelled distance
// after that request.
// Wheel radius and wheel base are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it; a write takes effect at the clock edge. One request is
// in work at a time; in_ready is high only when the sequencer is idle. The
// processing time is set by the bit-serial multiply/divide unit and the CORDIC,
// both iterating one step per cycle; an arc takes more operations than a straight
// segment, and a zero time step skips both units and goes straight to the output.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, a second result is held inside
// until the output register is free.
// Reset clears the pose and distance to zero and reloads the default radius
// and base.
`include "diff_drive_odometry_integrator_unit_defines.svh"

module diff_drive_odometry_integrator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [17:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] right_wheel_rate,
    input  logic signed [15:0] left_wheel_rate,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] position_x,
    output logic signed [31:0] position_y,
    output logic signed [15:0] heading,
    output logic [31:0]        distance_total
);

    localparam int SW = ddoi_pkg::CS_W;
    localparam int MW = ddoi_pkg::MD_W;
    localparam int CW = ddoi_pkg::MD_CW;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_SETUP = 16'b0000_0000_0000_0010,
        ST_COS0  = 16'b0000_0000_0000_0100,
        ST_MVDT  = 16'b0000_0000_0000_1000,
        ST_MNDT  = 16'b0000_0000_0001_0000,
        ST_DDTH  = 16'b0000_0000_0010_0000,
        ST_MANG  = 16'b0000_0000_0100_0000,
        ST_MSX   = 16'b0000_0000_1000_0000,
        ST_MSY   = 16'b0000_0001_0000_0000,
        ST_COS1  = 16'b0000_0010_0000_0000,
        ST_MPX   = 16'b0000_0100_0000_0000,
        ST_DPX   = 16'b0000_1000_0000_0000,
        ST_MPY   = 16'b0001_0000_0000_0000,
        ST_DPY   = 16'b0010_0000_0000_0000,
        ST_UPD   = 16'b0100_0000_0000_0000,
        ST_OUT   = 16'b1000_0000_0000_0000
    } state_t;

    function automatic logic signed [MW-1:0] trunc27(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] m;
        m = v[MW-1] ? -v : v;
        m = m >>> 27;
        return v[MW-1] ? -m : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MW:0] v);
        logic signed [31:0] r;
        if (v > (MW+1)'(33'sh0_7FFF_FFFF))
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < (MW+1)'(-33'sh0_8000_0000))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic                   started_reg, started_next;
    logic [15:0]            radius_reg, radius_next;
    logic [17:0]            base_reg, base_next;
    logic signed [31:0]     pose_x_reg, pose_x_next;
    logic signed [31:0]     pose_y_reg, pose_y_next;
    logic [15:0]            pose_heading_reg, pose_heading_next;
    logic [31:0]            travelled_reg, travelled_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [15:0]     wr_reg, wr_next;
    logic signed [15:0]     wl_reg, wl_next;
    logic [15:0]            dt_reg, dt_next;
    logic signed [32:0]     v25_reg, v25_next;
    logic signed [32:0]     n_reg, n_next;
    logic signed [34:0]     aa_reg, aa_next;
    logic signed [16:0]     d_reg, d_next;
    logic signed [SW-1:0]   s0_reg, s0_next;
    logic signed [SW-1:0]   c0_reg, c0_next;
    logic signed [SW-1:0]   s1_reg, s1_next;
    logic signed [SW-1:0]   c1_reg, c1_next;
    logic signed [MW-1:0]   prod_reg, prod_next;
    logic signed [MW-1:0]   tq_reg, tq_next;
    logic signed [MW-1:0]   dx_reg, dx_next;
    logic signed [MW-1:0]   dy_reg, dy_next;
    logic signed [33:0]     s24_reg, s24_next;
    logic [23:0]            dinc_reg, dinc_next;
    logic [31:0]            n32_reg, n32_next;
    logic signed [31:0]     out_x_reg, out_x_next;
    logic signed [31:0]     out_y_reg, out_y_next;
    logic [15:0]            out_h_reg, out_h_next;
    logic [31:0]            out_d_reg, out_d_next;

    ddoi_pkg::md_req_t      md_req;
    ddoi_pkg::md_rsp_t      md_rsp;
    ddoi_pkg::cd_req_t      cd_req;
    ddoi_pkg::cd_rsp_t      cd_rsp;

    logic [17:0]            base_eff;
    logic signed [16:0]     s_sum;
    logic signed [16:0]     d_diff;
    logic signed [33:0]     v_full;
    logic signed [33:0]     n_full;
    logic signed [35:0]     a_full;
    logic [32:0]            n_mag;
    logic [22:0]            base17;
    logic                   straight;
    logic signed [SW:0]     dsin;
    logic signed [SW:0]     dcos;
    logic [MW-1:0]          vdt_mag;
    logic                   md_state;
    logic [31:0]            hsum;
    logic [32:0]            tsum;

    ddoi_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    ddoi_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cd_req),
        .rsp   (cd_rsp)
    );

    always_comb
    begin
        base_eff = (base_reg == '0) ? 18'd1 : base_reg;
        s_sum    = 17'(wr_reg) + 17'(wl_reg);
        d_diff   = 17'(wr_reg) - 17'(wl_reg);
        v_full   = s_sum * $signed({1'b0, radius_reg});
        n_full   = d_diff * $signed({1'b0, radius_reg});
        a_full   = s_sum * $signed({1'b0, base_eff});
        n_mag    = n_reg[32] ? 33'(-n_reg) : 33'(n_reg);
        base17   = base_eff * 23'(ddoi_pkg::OMEGA_FLOOR);
        straight = (n_mag < 33'd128) && ({n_mag[6:0], 16'b0} < base17);
        dsin     = {s1_reg[SW-1], s1_reg} - {s0_reg[SW-1], s0_reg};
        dcos     = {c0_reg[SW-1], c0_reg} - {c1_reg[SW-1], c1_reg};
        vdt_mag  = md_rsp.result[MW-1] ? MW'(-md_rsp.result) : MW'(md_rsp.result);
        hsum     = n32_reg + 32'h0000_8000;
        tsum     = 33'(travelled_reg) + 33'(dinc_reg);
    end

    // Operand selection for the shared multiply/divide unit, and the CORDIC request.
    always_comb
    begin
        md_req.op    = ddoi_pkg::MD_MUL;
        md_req.a     = '0;
        md_req.b     = '0;
        md_req.nbits = '0;
        md_state     = 1'b1;
        case (state_reg)
            ST_MVDT:
            begin
                md_req.a     = MW'(v25_reg);
                md_req.b     = MW'(dt_reg);
                md_req.nbits = CW'(16);
            end
            ST_MNDT:
            begin
                md_req.a     = MW'(n_reg);
                md_req.b     = MW'(dt_reg);
                md_req.nbits = CW'(16);
            end
            ST_DDTH:
            begin
                md_req.op    = ddoi_pkg::MD_DIV;
                md_req.a     = prod_reg;
                md_req.b     = MW'(base_eff);
                md_req.nbits = CW'(48);
            end
            ST_MANG:
            begin
                md_req.a     = prod_reg;
                md_req.b     = MW'(ddoi_pkg::INV_PI_Q32);
                md_req.nbits = CW'(31);
            end
            ST_MSX:
            begin
                md_req.a     = MW'(s24_reg);
                md_req.b     = MW'(c0_reg);
                md_req.nbits = CW'(29);
            end
            ST_MSY:
            begin
                md_req.a     = MW'(s24_reg);
                md_req.b     = MW'(s0_reg);
                md_req.nbits = CW'(29);
            end
            ST_MPX:
            begin
                md_req.a     = MW'(aa_reg);
                md_req.b     = MW'(dsin);
                md_req.nbits = CW'(30);
            end
            ST_MPY:
            begin
                md_req.a     = MW'(aa_reg);
                md_req.b     = MW'(dcos);
                md_req.nbits = CW'(30);
            end
            ST_DPX, ST_DPY:
            begin
                md_req.op    = ddoi_pkg::MD_DIV;
                md_req.a     = tq_reg;
                md_req.b     = MW'(d_reg);
                md_req.nbits = CW'(36);
            end
            default:
            begin
                md_state = 1'b0;
            end
        endcase
        md_req.start = md_state && !started_reg;

        cd_req.start = ((state_reg == ST_COS0) || (state_reg == ST_COS1)) && !started_reg;
        cd_req.angle = (state_reg == ST_COS0) ? {pose_heading_reg, 16'b0} : n32_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        started_next      = started_reg;
        radius_next       = radius_reg;
        base_next         = base_reg;
        pose_x_next       = pose_x_reg;
        pose_y_next       = pose_y_reg;
        pose_heading_next = pose_heading_reg;
        travelled_next    = travelled_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        wr_next           = wr_reg;
        wl_next           = wl_reg;
        dt_next           = dt_reg;
        v25_next          = v25_reg;
        n_next            = n_reg;
        aa_next           = aa_reg;
        d_next            = d_reg;
        s0_next           = s0_reg;
        c0_next           = c0_reg;
        s1_next           = s1_reg;
        c1_next           = c1_reg;
        prod_next         = prod_reg;
        tq_next           = tq_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        s24_next          = s24_reg;
        dinc_next         = dinc_reg;
        n32_next          = n32_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_h_next        = out_h_reg;
        out_d_next        = out_d_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                ddoi_pkg::REG_WHEEL_RADIUS: radius_next = cfg_data[15:0];
                ddoi_pkg::REG_WHEEL_BASE:   base_next   = cfg_data;
                default:                    ;
            endcase
        end

        // Shared handshake with both iterative units: pulse start once, wait for done.
        if (md_req.start || cd_req.start)
        begin
            started_next = 1'b1;
        end
        else if (md_rsp.done || cd_rsp.done)
        begin
            started_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    wr_next    = right_wheel_rate;
                    wl_next    = left_wheel_rate;
                    dt_next    = time_step;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                v25_next   = v_full[32:0];
                n_next     = n_full[32:0];
                aa_next    = a_full[34:0];
                d_next     = d_diff;
                state_next = (dt_reg == '0) ? ST_OUT : ST_COS0;
            end
            ST_COS0:
            begin
                if (cd_rsp.done)
                begin
                    s0_next    = cd_rsp.sin;
                    c0_next    = cd_rsp.cos;
                    state_next = ST_MVDT;
                end
            end
            ST_MVDT:
            begin
                if (md_rsp.done)
                begin
                    s24_next   = 34'((md_rsp.result + MW'(64'sd65536)) >>> 17);
                    dinc_next  = 24'((vdt_mag + MW'(64'd16777216)) >> 25);
                    state_next = ST_MNDT;
                end
            end
            ST_MNDT:
            begin
                if (md_rsp.done)
                begin
                    prod_next  = md_rsp.result;
                    state_next = ST_DDTH;
                end
            end
            ST_DDTH:
            begin
                if (md_rsp.done)
                begin
                    prod_next  = md_rsp.result;
                    state_next = ST_MANG;
                end
            end
            ST_MANG:
            begin
                if (md_rsp.done)
                begin
                    n32_next   = {pose_heading_reg, 16'b0} + md_rsp.result[56:25];
                    state_next = straight ? ST_MSX : ST_COS1;
                end
            end
            ST_MSX:
            begin
                if (md_rsp.done)
                begin
                    dx_next    = (md_rsp.result + MW'(64'sd8589934592)) >>> 34;
                    state_next = ST_MSY;
                end
            end
            ST_MSY:
            begin
                if (md_rsp.done)
                begin
                    dy_next    = (md_rsp.result + MW'(64'sd8589934592)) >>> 34;
                    state_next = ST_UPD;
                end
            end
            ST_COS1:
            begin
                if (cd_rsp.done)
                begin
                    s1_next    = cd_rsp.sin;
                    c1_next    = cd_rsp.cos;
                    state_next = ST_MPX;
                end
            end
            ST_MPX:
            begin
                if (md_rsp.done)
                begin
                    tq_next    = trunc27(md_rsp.result);
                    state_next = ST_DPX;
                end
            end
            ST_DPX:
            begin
                if (md_rsp.done)
                begin
                    dx_next    = md_rsp.result;
                    state_next = ST_MPY;
                end
            end
            ST_MPY:
            begin
                if (md_rsp.done)
                begin
                    tq_next    = trunc27(md_rsp.result);
                    state_next = ST_DPY;
                end
            end
            ST_DPY:
            begin
                if (md_rsp.done)
                begin
                    dy_next    = md_rsp.result;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                pose_x_next       = sat32((MW+1)'(pose_x_reg) + (MW+1)'(dx_reg));
                pose_y_next       = sat32((MW+1)'(pose_y_reg) + (MW+1)'(dy_reg));
                pose_heading_next = hsum[31:16];
                travelled_next    = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                state_next        = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_x_next     = pose_x_reg;
                    out_y_next     = pose_y_reg;
                    out_h_next     = pose_heading_reg;
                    out_d_next     = travelled_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            started_reg      <= 1'b0;
            radius_reg       <= ddoi_pkg::RADIUS_RESET;
            base_reg         <= ddoi_pkg::BASE_RESET;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
            travelled_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            started_reg      <= started_next;
            radius_reg       <= radius_next;
            base_reg         <= base_next;
            pose_x_reg       <= pose_x_next;
            pose_y_reg       <= pose_y_next;
            pose_heading_reg <= pose_heading_next;
            travelled_reg    <= travelled_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_reg    <= wr_next;
        wl_reg    <= wl_next;
        dt_reg    <= dt_next;
        v25_reg   <= v25_next;
        n_reg     <= n_next;
        aa_reg    <= aa_next;
        d_reg     <= d_next;
        s0_reg    <= s0_next;
        c0_reg    <= c0_next;
        s1_reg    <= s1_next;
        c1_reg    <= c1_next;
        prod_reg  <= prod_next;
        tq_reg    <= tq_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        s24_reg   <= s24_next;
        dinc_reg  <= dinc_next;
        n32_reg   <= n32_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
        out_d_reg <= out_d_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign position_x     = out_x_reg;
    assign position_y     = out_y_reg;
    assign heading        = $signed(out_h_reg);
    assign distance_total = out_d_reg;

    `DDOI_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted while busy")
    `DDOI_ASSERT_IMP(a_one_unit_started, md_req.start, !cd_req.start, "both units started together")
    `DDOI_ASSERT_IMP(a_result_from_out, $rose(out_valid), $past(state_reg == ST_OUT), "result raised outside output step")
    `DDOI_ASSERT_NXT(a_zero_step_holds, (state_reg == ST_SETUP) && (dt_reg == '0), $stable(pose_x_reg) && $stable(pose_heading_reg), "zero time step changed the pose")

endmodule

// ===== hw/rtl/ddoi_muldiv.sv =====
// Shared multiply and divide unit, one bit of the operand per cycle.
// Depends on ddoi_pkg for the request and response types.
module ddoi_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  ddoi_pkg::md_req_t req,
    output ddoi_pkg::md_rsp_t rsp
);

    localparam int W = ddoi_pkg::MD_W;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    ddoi_pkg::md_op_t             op_reg, op_next;
    logic                         neg_reg, neg_next;
    logic [ddoi_pkg::MD_CW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                 acc_reg, acc_next;
    logic [W-1:0]                 sh_reg, sh_next;
    logic [W-1:0]                 mp_reg, mp_next;
    logic [W-1:0]                 quo_reg, quo_next;
    logic [W-1:0]                 res_reg, res_next;

    logic [W-1:0]                 mag_a;
    logic [W-1:0]                 mag_b;
    logic [W-1:0]                 trial;
    logic [W-1:0]                 val;
    logic [ddoi_pkg::MD_CW-1:0]   lsh;
    logic                         fits;

    always_comb
    begin
        mag_a = req.a[W-1] ? W'(-req.a) : W'(req.a);
        mag_b = req.b[W-1] ? W'(-req.b) : W'(req.b);
        lsh   = ddoi_pkg::MD_CW'(W) - req.nbits;
        trial = {acc_reg[W-2:0], sh_reg[W-1]};
        fits  = (trial >= mp_reg);
        val   = (op_reg == ddoi_pkg::MD_MUL) ? acc_reg : quo_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        mp_next   = mp_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            neg_next  = req.a[W-1] ^ req.b[W-1];
            cnt_next  = req.nbits;
            acc_next  = '0;
            quo_next  = '0;
            mp_next   = mag_b;
            sh_next   = (req.op == ddoi_pkg::MD_DIV) ? (mag_a << lsh) : mag_a;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                if (op_reg == ddoi_pkg::MD_MUL)
                begin
                    if (mp_reg[0])
                    begin
                        acc_next = acc_reg + sh_reg;
                    end
                    sh_next = sh_reg << 1;
                    mp_next = mp_reg >> 1;
                end
                else
                begin
                    acc_next = fits ? (trial - mp_reg) : trial;
                    quo_next = {quo_reg[W-2:0], fits};
                    sh_next  = sh_reg << 1;
                end
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (~val + 1'b1) : val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        mp_reg  <= mp_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = $signed(res_reg);

endmodule

// ===== hw/rtl/ddoi_cordic.sv =====
// Iterative CORDIC rotation giving sine and cosine of a binary angle.
// Depends on ddoi_pkg for the types, the gain and the arctangent table.
module ddoi_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  ddoi_pkg::cd_req_t req,
    output ddoi_pkg::cd_rsp_t rsp
);

    localparam int SW = ddoi_pkg::CS_W;
    localparam int ZW = ddoi_pkg::CZ_W;

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [ddoi_pkg::CORDIC_IW-1:0]   step_reg, step_next;
    logic signed [SW-1:0]             x_reg, x_next;
    logic signed [SW-1:0]             y_reg, y_next;
    logic signed [ZW-1:0]             z_reg, z_next;
    logic                             flip_reg, flip_next;
    logic signed [SW-1:0]             sin_reg, sin_next;
    logic signed [SW-1:0]             cos_reg, cos_next;

    logic                             fold;
    logic [31:0]                      folded;
    logic signed [SW-1:0]             ddx;
    logic signed [SW-1:0]             ddy;
    logic signed [ZW-1:0]             at;

    always_comb
    begin
        fold   = (req.angle > 32'h4000_0000) && (req.angle < 32'hC000_0000);
        folded = fold ? (req.angle - 32'h8000_0000) : req.angle;
        ddx    = y_reg >>> step_reg;
        ddy    = x_reg >>> step_reg;
        at     = ddoi_pkg::atan_angle(ddoi_pkg::ATAN_IW'(step_reg));

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        sin_next  = sin_reg;
        cos_next  = cos_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = ddoi_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = ZW'($signed(folded));
            flip_next = fold;
        end
        else if (busy_reg)
        begin
            if (step_reg != ddoi_pkg::CORDIC_IW'(ddoi_pkg::CORDIC_STEPS))
            begin
                step_next = step_reg + 1'b1;
                if (!z_reg[ZW-1])
                begin
                    x_next = x_reg - ddx;
                    y_next = y_reg + ddy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ddx;
                    y_next = y_reg - ddy;
                    z_next = z_reg + at;
                end
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                sin_next  = flip_reg ? -y_reg : y_reg;
                cos_next  = flip_reg ? -x_reg : x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sin  = sin_reg;
    assign rsp.cos  = cos_reg;

endmodule
